### rtl/ffsa_pkg.sv
`timescale 1ns / 1ps
package ffsa_pkg;
  localparam int unsigned SegmentsPerPool = 64;
  localparam int unsigned TableSize = 2 * SegmentsPerPool;
  localparam int unsigned IdxBits = $clog2(TableSize);
  localparam int unsigned LinkBits = IdxBits + 1;
  localparam int unsigned AddrBits = 20;
  localparam int unsigned EndBits = AddrBits + 1;
  localparam int unsigned OwnerBits = 16;
  localparam int unsigned RegBits = 21;
  localparam logic [LinkBits-1:0] Nil = LinkBits'(TableSize);

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNoFit = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  localparam logic [1:0] RegTotal = 2'd0;
  localparam logic [1:0] RegSystem = 2'd1;
  localparam logic [1:0] RegReserved = 2'd2;

  // Entry word: start, end, in_use, next, prev.
  localparam int unsigned EntryBits = AddrBits + EndBits + 1 + 2 * LinkBits;

  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [EndBits-1:0]  stop;
    logic                in_use;
    logic [LinkBits-1:0] next;
    logic [LinkBits-1:0] prev;
  } entry_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_WALK_RD, S_WALK_CHK, S_SPARE_RD, S_SPARE_CHK,
    S_SPLIT_NRD, S_SPLIT_NWR, S_SPLIT_Q, S_SPLIT_P,
    S_FREE_LRD, S_FREE_LCHK, S_FREE_NRD, S_FREE_NCHK,
    S_MRG_L, S_MRG_LNN, S_MRG_LREL, S_MRG_N, S_MRG_NNRD, S_MRG_NNWR,
    S_MRG_NREL, S_MRG_PWR, S_DONE
  } state_e;
endpackage

### rtl/first_fit_segment_allocator.sv
`timescale 1ns / 1ps
// Channel | Handshake                   | Payload
// in      | in_valid_i / in_ready_o     | kind, owner_id, request_size, free_address,
//         |                             | free_from_system
// out     | out_valid_o / out_ready_i   | status, address
// cfg     | cfg_we_i                    | cfg_index_i, cfg_data_i
// One item at a time: the walk reads and checks each list entry in turn (one table
// read port), then updates the list and registers the result.
// Reset and every total_bytes write run a table rebuild over all entries; no item is
// taken meanwhile. A waiting result blocks the next item until taken.
module first_fit_segment_allocator import ffsa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [RegBits-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [OwnerBits-1:0] owner_id_i,
  input  logic [RegBits-1:0]   request_size_i,
  input  logic [AddrBits-1:0]  free_address_i,
  input  logic                 free_from_system_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [AddrBits-1:0]  address_o
);
  logic [RegBits-1:0] tot_q, sys_q, res_q;
  logic rebuild;
  logic mem_we, own_we;
  logic [IdxBits-1:0] waddr, raddr;
  entry_t wdata, rdata;
  logic [OwnerBits-1:0] own_wdata, own_rdata;

  assign rebuild = cfg_we_i && (cfg_index_i == RegTotal);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= RegBits'(1048576); sys_q <= RegBits'(65536); res_q <= RegBits'(256);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegTotal: tot_q <= cfg_data_i;
        RegSystem: sys_q <= cfg_data_i;
        RegReserved: res_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ffsa_ctrl u_ctrl (
    .clk_i, .rst_ni, .rebuild_i(rebuild),
    .tot_i((cfg_we_i && cfg_index_i == RegTotal) ? cfg_data_i : tot_q),
    .sys_i(sys_q), .res_i(res_q),
    .in_valid_i, .in_ready_o, .kind_i, .owner_id_i, .request_size_i,
    .free_address_i, .free_from_system_i, .out_valid_o, .out_ready_i,
    .status_o, .address_o,
    .mem_we_o(mem_we), .mem_waddr_o(waddr), .mem_wdata_o(wdata),
    .mem_raddr_o(raddr), .mem_rdata_i(rdata),
    .own_we_o(own_we), .own_wdata_o(own_wdata)
  );

  ffsa_ram #(.Width(EntryBits), .Depth(TableSize)) u_seg (
    .clk_i, .we_i(mem_we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  ffsa_ram #(.Width(OwnerBits), .Depth(TableSize)) u_own (
    .clk_i, .we_i(own_we), .waddr_i(waddr), .wdata_i(own_wdata),
    .raddr_i(raddr), .rdata_o(own_rdata)
  );

  logic unused_own;
  assign unused_own = ^own_rdata;

  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("item taken with result pending");
  a_ok_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StOk) |-> address_o == '0)
    else $error("address on failure");
  a_owner_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    own_we |-> mem_we) else $error("owner written alone");
endmodule

### rtl/ffsa_ram.sv
`timescale 1ns / 1ps
module ffsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/ffsa_ctrl.sv
`timescale 1ns / 1ps
module ffsa_ctrl import ffsa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rebuild_i,
  input  logic [RegBits-1:0]   tot_i,
  input  logic [RegBits-1:0]   sys_i,
  input  logic [RegBits-1:0]   res_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [OwnerBits-1:0] owner_id_i,
  input  logic [RegBits-1:0]   request_size_i,
  input  logic [AddrBits-1:0]  free_address_i,
  input  logic                 free_from_system_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [AddrBits-1:0]  address_o,
  output logic                 mem_we_o,
  output logic [IdxBits-1:0]   mem_waddr_o,
  output entry_t               mem_wdata_o,
  output logic [IdxBits-1:0]   mem_raddr_o,
  input  entry_t               mem_rdata_i,
  output logic                 own_we_o,
  output logic [OwnerBits-1:0] own_wdata_o
);
  state_e state_q, state_d;
  logic [IdxBits:0] init_q, init_d;
  logic [LinkBits-1:0] head_q [2];
  logic [LinkBits-1:0] head_d [2];
  logic [LinkBits-1:0] spare_q, spare_d;
  logic [LinkBits-1:0] p_q, p_d, q_q, q_d, x_q, x_d;
  logic [IdxBits:0] steps_q, steps_d;
  entry_t pe_q, pe_d, xe_q, xe_d, ne_q, ne_d;
  logic kind_q, kind_d;
  logic [OwnerBits-1:0] own_q, own_d;
  logic [RegBits-1:0] size_q, size_d;
  logic [AddrBits-1:0] where_q, where_d;
  logic [1:0] st_q, st_d;
  logic [AddrBits-1:0] ad_q, ad_d;
  logic ov_q, ov_d;

  logic [EndBits-1:0] ct, cs, cr, len;
  logic hs0, hs1;
  always_comb begin
    ct = tot_i;
    if (ct == '0) ct = EndBits'(1);
    if (ct > EndBits'(1 << AddrBits)) ct = EndBits'(1 << AddrBits);
    cs = (sys_i > ct) ? ct : sys_i;
    cr = (res_i > cs) ? cs : res_i;
    hs0 = cr < cs;
    hs1 = cs < ct;
  end
  assign len = mem_rdata_i.stop - EndBits'(mem_rdata_i.start);

  assign in_ready_o = (state_q == S_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign address_o = ad_q;

  always_comb begin
    state_d = state_q; init_d = init_q; head_d = head_q; spare_d = spare_q;
    p_d = p_q; q_d = q_q; x_d = x_q; steps_d = steps_q;
    pe_d = pe_q; xe_d = xe_q; ne_d = ne_q;
    kind_d = kind_q; own_d = own_q; size_d = size_q;
    where_d = where_q; st_d = st_q; ad_d = ad_q; ov_d = ov_q;
    mem_we_o = 1'b0; mem_waddr_o = '0; mem_wdata_o = '0; mem_raddr_o = '0;
    own_we_o = 1'b0; own_wdata_o = own_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      S_INIT: begin
        // rebuild sweep
        mem_we_o = 1'b1;
        mem_waddr_o = init_q[IdxBits-1:0];
        own_we_o = 1'b1;
        own_wdata_o = '0;
        mem_wdata_o.prev = Nil;
        if (init_q == '0 && hs0) begin
          mem_wdata_o.start = cr[AddrBits-1:0]; mem_wdata_o.stop = cs; mem_wdata_o.next = Nil;
        end else if (init_q == (IdxBits+1)'(hs0) && hs1) begin
          mem_wdata_o.start = cs[AddrBits-1:0]; mem_wdata_o.stop = ct; mem_wdata_o.next = Nil;
        end else begin
          mem_wdata_o.next = (init_q == (IdxBits+1)'(TableSize - 1)) ? Nil
                             : LinkBits'(init_q + 1'b1);
        end
        head_d[0] = hs0 ? LinkBits'(0) : Nil;
        head_d[1] = hs1 ? LinkBits'(hs0) : Nil;
        spare_d = LinkBits'(32'(hs0) + 32'(hs1));
        init_d = init_q + 1'b1;
        if (init_q == (IdxBits+1)'(TableSize - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          kind_d = kind_i; own_d = owner_id_i; size_d = request_size_i;
          where_d = free_address_i; steps_d = '0;
          p_d = kind_i ? head_q[!free_from_system_i] : head_q[owner_id_i != '0];
          ad_d = '0;
          if (!kind_i && request_size_i == '0) begin
            st_d = StNoFit; state_d = S_DONE;
          end else begin
            state_d = S_WALK_RD;
          end
        end
      end
      S_WALK_RD: begin
        mem_raddr_o = p_q[IdxBits-1:0];
        if (p_q[IdxBits] || steps_q[IdxBits]) begin
          st_d = kind_q ? StNotFound : StNoFit; state_d = S_DONE;
        end else state_d = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        pe_d = mem_rdata_i;
        steps_d = steps_q + 1'b1;
        if (!kind_q && !mem_rdata_i.in_use && len >= EndBits'(size_q)) begin
          if (len > EndBits'(size_q)) state_d = S_SPARE_RD;
          else begin
            mem_we_o = 1'b1; mem_waddr_o = p_q[IdxBits-1:0];
            mem_wdata_o = mem_rdata_i; mem_wdata_o.in_use = 1'b1;
            own_we_o = 1'b1;
            st_d = StOk; ad_d = mem_rdata_i.start; state_d = S_DONE;
          end
        end else if (kind_q && mem_rdata_i.start == where_q) begin
          state_d = S_FREE_LRD;
        end else begin
          p_d = mem_rdata_i.next; state_d = S_WALK_RD;
        end
      end
      S_SPARE_RD: begin
        mem_raddr_o = spare_q[IdxBits-1:0];
        q_d = spare_q;
        if (spare_q[IdxBits]) begin
          st_d = StFull; state_d = S_DONE;
        end else state_d = S_SPARE_CHK;
      end
      S_SPARE_CHK: begin
        spare_d = mem_rdata_i.next;
        state_d = pe_q.next[IdxBits] ? S_SPLIT_Q : S_SPLIT_NRD;
      end
      S_SPLIT_NRD: begin
        mem_raddr_o = pe_q.next[IdxBits-1:0];
        state_d = S_SPLIT_NWR;
      end
      S_SPLIT_NWR: begin
        mem_we_o = 1'b1; mem_waddr_o = pe_q.next[IdxBits-1:0];
        mem_wdata_o = mem_rdata_i; mem_wdata_o.prev = q_q;
        state_d = S_SPLIT_Q;
      end
      S_SPLIT_Q: begin
        mem_we_o = 1'b1; mem_waddr_o = q_q[IdxBits-1:0];
        mem_wdata_o.start = pe_q.start + size_q[AddrBits-1:0];
        mem_wdata_o.stop = pe_q.stop; mem_wdata_o.in_use = 1'b0;
        mem_wdata_o.next = pe_q.next; mem_wdata_o.prev = p_q;
        state_d = S_SPLIT_P;
      end
      S_SPLIT_P: begin
        mem_we_o = 1'b1; mem_waddr_o = p_q[IdxBits-1:0];
        mem_wdata_o = pe_q; mem_wdata_o.in_use = 1'b1; mem_wdata_o.next = q_q;
        mem_wdata_o.stop = EndBits'(pe_q.start) + EndBits'(size_q);
        own_we_o = 1'b1;
        st_d = StOk; ad_d = pe_q.start; state_d = S_DONE;
      end
      S_FREE_LRD: begin
        pe_d.in_use = 1'b0;
        mem_raddr_o = pe_q.prev[IdxBits-1:0];
        state_d = pe_q.prev[IdxBits] ? S_FREE_NRD : S_FREE_LCHK;
      end
      S_FREE_LCHK: begin
        xe_d = mem_rdata_i; x_d = pe_q.prev;
        state_d = mem_rdata_i.in_use ? S_FREE_NRD : S_MRG_L;
      end
      S_MRG_L: begin
        // left absorbs p; p goes to spare chain
        xe_d.stop = pe_q.stop; xe_d.next = pe_q.next;
        mem_we_o = 1'b1; mem_waddr_o = p_q[IdxBits-1:0];
        mem_wdata_o = pe_q; mem_wdata_o.in_use = 1'b0; mem_wdata_o.prev = Nil;
        mem_wdata_o.next = spare_q;
        spare_d = p_q;
        state_d = pe_q.next[IdxBits] ? S_MRG_LREL : S_MRG_LNN;
      end
      S_MRG_LNN: begin
        mem_raddr_o = pe_q.next[IdxBits-1:0];
        state_d = S_MRG_LREL;
      end
      S_MRG_LREL: begin
        if (!pe_q.next[IdxBits]) begin
          mem_we_o = 1'b1; mem_waddr_o = pe_q.next[IdxBits-1:0];
          mem_wdata_o = mem_rdata_i; mem_wdata_o.prev = x_q;
        end
        p_d = x_q; pe_d = xe_q;
        state_d = S_FREE_NRD;
      end
      S_FREE_NRD: begin
        mem_raddr_o = pe_q.next[IdxBits-1:0];
        state_d = pe_q.next[IdxBits] ? S_MRG_PWR : S_FREE_NCHK;
      end
      S_FREE_NCHK: begin
        ne_d = mem_rdata_i; x_d = pe_q.next;
        state_d = mem_rdata_i.in_use ? S_MRG_PWR : S_MRG_N;
      end
      S_MRG_N: begin
        pe_d.stop = ne_q.stop; pe_d.next = ne_q.next;
        mem_we_o = 1'b1; mem_waddr_o = x_q[IdxBits-1:0];
        mem_wdata_o = ne_q; mem_wdata_o.in_use = 1'b0; mem_wdata_o.prev = Nil;
        mem_wdata_o.next = spare_q;
        spare_d = x_q;
        state_d = ne_q.next[IdxBits] ? S_MRG_PWR : S_MRG_NNRD;
      end
      S_MRG_NNRD: begin
        mem_raddr_o = pe_q.next[IdxBits-1:0];
        state_d = S_MRG_NNWR;
      end
      S_MRG_NNWR: begin
        mem_we_o = 1'b1; mem_waddr_o = pe_q.next[IdxBits-1:0];
        mem_wdata_o = mem_rdata_i; mem_wdata_o.prev = p_q;
        state_d = S_MRG_PWR;
      end
      S_MRG_PWR: begin
        mem_we_o = 1'b1; mem_waddr_o = p_q[IdxBits-1:0]; mem_wdata_o = pe_q;
        st_d = StOk; state_d = S_DONE;
      end
      S_DONE: begin
        ov_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (rebuild_i) begin
      state_d = S_INIT; init_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; init_q <= '0; head_q[0] <= Nil; head_q[1] <= Nil;
      spare_q <= Nil; ov_q <= 1'b0; steps_q <= '0;
    end else begin
      state_q <= state_d; init_q <= init_d; head_q <= head_d;
      spare_q <= spare_d; ov_q <= ov_d; steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; q_q <= q_d; x_q <= x_d; pe_q <= pe_d; xe_q <= xe_d; ne_q <= ne_d;
    kind_q <= kind_d; own_q <= own_d; size_q <= size_d;
    where_q <= where_d; st_q <= st_d; ad_q <= ad_d;
  end
endmodule

### dv/ffsa_checker.sv
`timescale 1ns / 1ps
module ffsa_checker import ffsa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [RegBits-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 kind_i,
  input  logic [OwnerBits-1:0] owner_id_i,
  input  logic [RegBits-1:0]   request_size_i,
  input  logic [AddrBits-1:0]  free_address_i,
  input  logic                 free_from_system_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [1:0]           status_i,
  input  logic [AddrBits-1:0]  address_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  typedef struct packed {
    logic [1:0]          status;
    logic [AddrBits-1:0] address;
  } grant_t;

  logic [RegBits-1:0] tot_r, sys_r, res_r;
  logic [EndBits-1:0]  seg_lo [TableSize];
  logic [EndBits-1:0]  seg_hi [TableSize];
  logic                seg_busy [TableSize];
  int                  seg_nx [TableSize];
  int                  seg_pv [TableSize];
  int                  head [2];
  int                  spare;
  grant_t              grant_q [$];
  int                  fails;

  assign fail_count_o = fails;

  function automatic void rebuild_pools();
    int t, s, r, used;
    t = tot_r; s = sys_r; r = res_r;
    if (t < 1) t = 1;
    if (t > (1 << AddrBits)) t = 1 << AddrBits;
    if (s > t) s = t;
    if (r > s) r = s;
    used = 0;
    for (int i = 0; i < TableSize; i++) begin
      seg_lo[i] = '0; seg_hi[i] = '0; seg_busy[i] = 1'b0;
      seg_nx[i] = TableSize; seg_pv[i] = TableSize;
    end
    head[0] = TableSize; head[1] = TableSize;
    if (r < s) begin
      seg_lo[used] = EndBits'(r); seg_hi[used] = EndBits'(s); head[0] = used; used++;
    end
    if (s < t) begin
      seg_lo[used] = EndBits'(s); seg_hi[used] = EndBits'(t); head[1] = used; used++;
    end
    spare = used;
    for (int i = used; i < TableSize; i++) seg_nx[i] = i + 1;
  endfunction

  function automatic void put_spare(int e);
    seg_busy[e] = 1'b0; seg_pv[e] = TableSize; seg_nx[e] = spare; spare = e;
  endfunction

  function automatic grant_t alloc_segment(logic [OwnerBits-1:0] own, int sz);
    grant_t g;
    int p, q, n, k;
    g = '0;
    if (sz == 0) begin g.status = StNoFit; return g; end
    p = head[own == 0 ? 0 : 1];
    for (k = 0; p < TableSize && k < TableSize; k++) begin
      if (!seg_busy[p] && int'(seg_hi[p] - seg_lo[p]) >= sz) break;
      p = seg_nx[p];
    end
    if (p >= TableSize || k >= TableSize) begin g.status = StNoFit; return g; end
    if (int'(seg_hi[p] - seg_lo[p]) > sz) begin
      q = spare;
      if (q >= TableSize) begin g.status = StFull; return g; end
      spare = seg_nx[q];
      seg_lo[q] = seg_lo[p] + EndBits'(sz); seg_hi[q] = seg_hi[p]; seg_busy[q] = 1'b0;
      n = seg_nx[p]; seg_nx[q] = n; seg_pv[q] = p;
      if (n < TableSize) seg_pv[n] = q;
      seg_nx[p] = q; seg_hi[p] = seg_lo[q];
    end
    seg_busy[p] = 1'b1;
    g.status = StOk;
    g.address = seg_lo[p][AddrBits-1:0];
    return g;
  endfunction

  function automatic grant_t free_segment(logic [AddrBits-1:0] where, int pool);
    grant_t g;
    int p, l, n, nn, k;
    g = '0;
    p = head[pool];
    for (k = 0; p < TableSize && k < TableSize; k++) begin
      if (seg_lo[p] == EndBits'(where)) break;
      p = seg_nx[p];
    end
    if (p >= TableSize || k >= TableSize) begin g.status = StNotFound; return g; end
    l = seg_pv[p]; n = seg_nx[p];
    seg_busy[p] = 1'b0;
    if (l < TableSize && !seg_busy[l]) begin
      seg_hi[l] = seg_hi[p]; seg_nx[l] = n;
      if (n < TableSize) seg_pv[n] = l;
      put_spare(p);
      p = l;
    end
    if (n < TableSize && !seg_busy[n]) begin
      nn = seg_nx[n];
      seg_hi[p] = seg_hi[n]; seg_nx[p] = nn;
      if (nn < TableSize) seg_pv[nn] = p;
      put_spare(n);
    end
    g.status = StOk;
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t exp_g;
    if (!rst_ni) begin
      tot_r = 21'd1048576; sys_r = 21'd65536; res_r = 21'd256;
      rebuild_pools();
      grant_q.delete();
      fails = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (grant_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result status=%0d addr=%0h", status_i, address_i);
        end else begin
          exp_g = grant_q.pop_front();
          if (status_i !== exp_g.status || address_i !== exp_g.address) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp status=%0d addr=%0h, got status=%0d addr=%0h",
                       exp_g.status, exp_g.address, status_i, address_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (kind_i == 1'b0) grant_q.push_back(alloc_segment(owner_id_i, request_size_i));
        else grant_q.push_back(free_segment(free_address_i, free_from_system_i ? 0 : 1));
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegTotal: begin tot_r = cfg_data_i; rebuild_pools(); end
          RegSystem: sys_r = cfg_data_i;
          RegReserved: res_r = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = grant_q.size();
  end
endmodule

### dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import ffsa_pkg::*;
  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [1:0] cfg_index_i = '0;
  logic [RegBits-1:0] cfg_data_i = '0;
  logic in_valid_i = 0, in_ready_o;
  logic kind_i = 0;
  logic [OwnerBits-1:0] owner_id_i = '0;
  logic [RegBits-1:0] request_size_i = '0;
  logic [AddrBits-1:0] free_address_i = '0;
  logic free_from_system_i = 0;
  logic out_valid_o, out_ready_i = 0;
  logic [1:0] status_o;
  logic [AddrBits-1:0] address_o;
  int fail_count, pending;
  bit hold_off = 0;
  logic [AddrBits-1:0] granted [$];

  always #6 clk_i = ~clk_i;

  first_fit_segment_allocator u_dut (.*);

  ffsa_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .owner_id_i, .request_size_i,
    .free_address_i, .free_from_system_i, .out_valid_i(out_valid_o), .out_ready_i,
    .status_i(status_o), .address_i(address_o), .fail_count_o(fail_count),
    .pending_o(pending));

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i && status_o == StOk && address_o != 0)
      granted.push_back(address_o);
    if (hold_off) out_ready_i <= 0;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_item(bit k, logic [15:0] own, logic [20:0] sz,
                           logic [19:0] fa, bit fs);
    @(posedge clk_i);
    in_valid_i <= 1; kind_i <= k; owner_id_i <= own; request_size_i <= sz;
    free_address_i <= fa; free_from_system_i <= fs;
    do @(posedge clk_i); while (!in_ready_o);
    in_valid_i <= 0;
  endtask

  task automatic drain_and_config(logic [1:0] idx, logic [20:0] val);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    cfg_we_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (idx == RegTotal) granted.delete();
  endtask

  task automatic rand_item();
    int r, pick;
    logic [19:0] fa;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      send_item(0, ($urandom_range(0, 1) ? 16'($urandom) : 16'd0),
                ($urandom_range(0, 9) == 0 ? 21'($urandom) : 21'($urandom_range(1, 4096))),
                20'($urandom), $urandom_range(0, 1));
    end else if (r < 85 && granted.size() > 0) begin
      pick = $urandom_range(0, granted.size() - 1);
      fa = granted[pick];
      granted.delete(pick);
      send_item(1, 16'($urandom), 21'($urandom), fa, $urandom_range(0, 1));
    end else begin
      send_item(1, 16'($urandom), 21'($urandom), 20'($urandom), $urandom_range(0, 1));
    end
  endtask

  initial begin
    int burst;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    // directed
    send_item(0, 16'd0, 21'd0, 20'd0, 0);
    send_item(0, 16'd0, 21'd1, 20'd0, 0);
    send_item(0, 16'hFFFF, 21'h1FFFFF, 20'hFFFFF, 1);
    send_item(0, 16'd7, 21'd983040, 20'd0, 0);
    send_item(1, 16'd0, 21'd0, 20'd65536, 0);
    send_item(1, 16'd0, 21'd0, 20'd65536, 0);
    send_item(1, 16'd0, 21'd0, 20'd256, 1);
    send_item(1, 16'd0, 21'd0, 20'd12345, 1);
    send_item(1, 16'd0, 21'd0, 20'hFFFFF, 0);
    for (int i = 0; i < 8; i++) send_item(0, 16'd0, 21'd16, 20'd0, 0);
    send_item(1, 16'd0, 21'd0, 20'd288, 1);
    send_item(1, 16'd0, 21'd0, 20'd272, 1);
    send_item(1, 16'd0, 21'd0, 20'd304, 1);
    drain_and_config(RegSystem, 21'd0);
    drain_and_config(RegReserved, 21'h1FFFFF);
    drain_and_config(RegTotal, 21'h1FFFFF);
    send_item(0, 16'd0, 21'd1, 20'd0, 0);
    send_item(0, 16'd3, 21'd5, 20'd0, 0);
    drain_and_config(RegSystem, 21'd200);
    drain_and_config(RegReserved, 21'd0);
    drain_and_config(RegTotal, 21'd0);
    send_item(0, 16'd0, 21'd1, 20'd0, 0);
    drain_and_config(RegTotal, 21'd4096);
    // long stall on the result side while items keep coming
    hold_off = 1;
    fork
      begin repeat (400) @(posedge clk_i); hold_off = 0; end
      for (int i = 0; i < 12; i++) rand_item();
    join
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: begin drain_and_config(RegSystem, 21'd30000); drain_and_config(RegReserved, 21'd1);
                 drain_and_config(RegTotal, 21'd100000); end
        2: begin drain_and_config(RegSystem, 21'd65536); drain_and_config(RegReserved, 21'd256);
                 drain_and_config(RegTotal, 21'd1048576); end
        3: begin drain_and_config(RegSystem, 21'd2048); drain_and_config(RegReserved, 21'd0);
                 drain_and_config(RegTotal, 21'd300000); end
        default: ;
      endcase
      for (int n = 0; n < 300;) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst; b++) begin rand_item(); n++; end
        repeat ($urandom_range(0, 8)) @(posedge clk_i);
      end
    end
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #200ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule

### sim.f
rtl/ffsa_pkg.sv
rtl/ffsa_ram.sv
rtl/ffsa_ctrl.sv
rtl/first_fit_segment_allocator.sv
dv/ffsa_checker.sv
dv/tb.sv
